/* rtl/pbsq_pkg.sv */
// Shared types, constants and lookup functions of the 6x6 Polybius square cipher.
// Used by the front end, queue, result stage, top level and bench; depends on nothing.
`default_nettype none

package pbsq_pkg;

  localparam int SqSide     = 6;
  localparam int SqCells    = 36;
  localparam int QueueDepth = 4;

  localparam logic [7:0] AsciiSpace = 8'h20;
  localparam logic [7:0] AsciiA     = 8'h41;
  localparam logic [7:0] AsciiZ     = 8'h5A;
  localparam logic [7:0] AsciiLowA  = 8'h61;
  localparam logic [7:0] AsciiLowZ  = 8'h7A;
  localparam logic [7:0] AsciiOne   = 8'h31;
  localparam logic [7:0] AsciiNine  = 8'h39;
  localparam logic [7:0] CaseOffset = 8'h20;

  // register indexes on the config port
  localparam logic RegKey  = 1'b0;
  localparam logic RegMode = 1'b1;

  // one queued job: one or two result words
  typedef struct packed {
    logic       two;
    logic [7:0] sym0;
    logic       err0;
    logic [7:0] sym1;
  } job_t;

  function automatic logic [7:0] fold_upper(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= AsciiLowA && c <= AsciiLowZ) r = c - CaseOffset;
    return r;
  endfunction

  // {found, index} of a symbol in the 36-symbol alphabet
  function automatic logic [6:0] sym_lookup(input logic [7:0] c);
    logic [6:0] r;
    r = '0;
    if (c >= AsciiA && c <= AsciiZ)          r = {1'b1, 6'(c - AsciiA)};
    else if (c == AsciiSpace)                r = {1'b1, 6'd26};
    else if (c >= AsciiOne && c <= AsciiNine) r = {1'b1, 6'(c - AsciiOne) + 6'd27};
    return r;
  endfunction

  function automatic logic [7:0] sym_at(input logic [5:0] idx);
    logic [7:0] r;
    if (idx < 6'd26)       r = AsciiA + 8'(idx);
    else if (idx == 6'd26) r = AsciiSpace;
    else                   r = AsciiOne + 8'(idx - 6'd27);
    return r;
  endfunction

  // row headers N O R M A L
  function automatic logic [7:0] row_letter(input logic [2:0] row);
    logic [7:0] r;
    case (row)
      3'd0:    r = "N";
      3'd1:    r = "O";
      3'd2:    r = "R";
      3'd3:    r = "M";
      3'd4:    r = "A";
      default: r = "L";
    endcase
    return r;
  endfunction

  // column headers X I F R A T
  function automatic logic [7:0] col_letter(input logic [2:0] col);
    logic [7:0] r;
    case (col)
      3'd0:    r = "X";
      3'd1:    r = "I";
      3'd2:    r = "F";
      3'd3:    r = "R";
      3'd4:    r = "A";
      default: r = "T";
    endcase
    return r;
  endfunction

  // {found, row}
  function automatic logic [3:0] row_lookup(input logic [7:0] c);
    logic [3:0] r;
    case (c)
      "N":     r = {1'b1, 3'd0};
      "O":     r = {1'b1, 3'd1};
      "R":     r = {1'b1, 3'd2};
      "M":     r = {1'b1, 3'd3};
      "A":     r = {1'b1, 3'd4};
      "L":     r = {1'b1, 3'd5};
      default: r = '0;
    endcase
    return r;
  endfunction

  // {found, col}
  function automatic logic [3:0] col_lookup(input logic [7:0] c);
    logic [3:0] r;
    case (c)
      "X":     r = {1'b1, 3'd0};
      "I":     r = {1'b1, 3'd1};
      "F":     r = {1'b1, 3'd2};
      "R":     r = {1'b1, 3'd3};
      "A":     r = {1'b1, 3'd4};
      "T":     r = {1'b1, 3'd5};
      default: r = '0;
    endcase
    return r;
  endfunction

  // cell position 0..35 -> row 0..5, by compare chain
  function automatic logic [2:0] row_of(input logic [5:0] p);
    logic [2:0] r;
    if (p >= 6'd30)      r = 3'd5;
    else if (p >= 6'd24) r = 3'd4;
    else if (p >= 6'd18) r = 3'd3;
    else if (p >= 6'd12) r = 3'd2;
    else if (p >= 6'd6)  r = 3'd1;
    else                 r = 3'd0;
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/pbsq_front.sv */
// Front end: takes input words, keeps the half-pair state, builds result jobs.
// Depends on pbsq_pkg.
`default_nettype none

module pbsq_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [5:0]        key_rotation,
  input  wire logic              decrypt_mode,
  input  wire logic [7:0]        in_symbol,
  input  wire logic              end_of_text,
  input  wire logic              accept,
  output      logic              job_valid,
  output      pbsq_pkg::job_t    job
);
  import pbsq_pkg::*;

  logic       half_pair_waiting;
  logic [2:0] held_row;
  logic       held_row_bad;
  logic       half_pair_waiting_next;
  logic [2:0] held_row_next;
  logic       held_row_bad_next;

  logic [7:0] c;
  logic [5:0] key;
  logic [6:0] sym_hit;
  logic [3:0] row_hit;
  logic [3:0] col_hit;
  logic [6:0] p_sum;
  logic [5:0] p;
  logic [2:0] p_row;
  logic [5:0] p_col;
  logic [6:0] d_sum;
  logic [5:0] d_idx;

  assign c       = fold_upper(in_symbol);
  assign key     = (key_rotation >= 6'(SqCells)) ? key_rotation - 6'(SqCells) : key_rotation;
  assign sym_hit = sym_lookup(c);
  assign row_hit = row_lookup(c);
  assign col_hit = col_lookup(c);

  // encrypt: p = (a - key) mod 36
  assign p_sum = {1'b0, sym_hit[5:0]} + 7'(SqCells) - {1'b0, key};
  assign p     = (p_sum >= 7'(SqCells)) ? 6'(p_sum - 7'(SqCells)) : p_sum[5:0];
  assign p_row = row_of(p);
  assign p_col = p - 6'(p_row) * 6'(SqSide);

  // decrypt: (row*6 + col + key) mod 36, at most 70 before the wrap
  assign d_sum = 7'(held_row) * 7'(SqSide) + 7'(col_hit[2:0]) + 7'(key);
  assign d_idx = (d_sum >= 7'(SqCells)) ? 6'(d_sum - 7'(SqCells)) : d_sum[5:0];

  always_comb begin
    half_pair_waiting_next = half_pair_waiting;
    held_row_next          = held_row;
    held_row_bad_next      = held_row_bad;
    job_valid              = 1'b0;
    job.two                = 1'b0;
    job.sym0               = '0;
    job.err0               = 1'b1;
    job.sym1               = '0;
    if (accept) begin
      if (!decrypt_mode) begin
        half_pair_waiting_next = 1'b0;
        held_row_next          = '0;
        held_row_bad_next      = 1'b0;
        job_valid              = 1'b1;
        if (sym_hit[6]) begin
          job.two  = 1'b1;
          job.sym0 = row_letter(p_row);
          job.err0 = 1'b0;
          job.sym1 = col_letter(p_col[2:0]);
        end
      end else if (!half_pair_waiting) begin
        if (end_of_text) begin
          held_row_next     = '0;
          held_row_bad_next = 1'b0;
          job_valid         = 1'b1;
        end else begin
          half_pair_waiting_next = 1'b1;
          held_row_bad_next      = !row_hit[3];
          held_row_next          = row_hit[3] ? row_hit[2:0] : 3'd0;
        end
      end else begin
        half_pair_waiting_next = 1'b0;
        held_row_next          = '0;
        held_row_bad_next      = 1'b0;
        job_valid              = 1'b1;
        if (!held_row_bad && col_hit[3]) begin
          job.sym0 = sym_at(d_idx);
          job.err0 = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      half_pair_waiting <= 1'b0;
      held_row          <= '0;
      held_row_bad      <= 1'b0;
    end else begin
      half_pair_waiting <= half_pair_waiting_next;
      held_row          <= held_row_next;
      held_row_bad      <= held_row_bad_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/pbsq_queue.sv */
// Short job queue between the front end and the result stage.
// Depends on pbsq_pkg.
`default_nettype none

module pbsq_queue #(
  parameter int DEPTH = pbsq_pkg::QueueDepth
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           wr_en,
  input  wire pbsq_pkg::job_t wr_data,
  input  wire logic           rd_en,
  output      pbsq_pkg::job_t rd_data,
  output      logic           full,
  output      logic           empty
);
  import pbsq_pkg::*;

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  job_t            mem [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign full    = (count == CntW'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (rd_en) rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (wr_en && !rd_en)      count <= count + 1'b1;
      else if (rd_en && !wr_en) count <= count - 1'b1;
    end
  end

endmodule

`default_nettype wire

/* rtl/pbsq_back.sv */
// Result stage: unpacks each job into one or two result words on the output queue side.
// Depends on pbsq_pkg.
`default_nettype none

module pbsq_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire pbsq_pkg::job_t q_data,
  input  wire logic           q_empty,
  output      logic           q_pop,
  output      logic [7:0]     out_symbol,
  output      logic           error,
  output      logic           last,
  output      logic           empty,
  input  wire logic           pop
);
  import pbsq_pkg::*;

  job_t cur;
  logic cur_valid;
  logic phase;    // 1: second word of a two-word job
  logic advance;

  assign advance    = pop && cur_valid && (phase || !cur.two);
  assign q_pop      = (!cur_valid || advance) && !q_empty;
  assign empty      = !cur_valid;
  assign out_symbol = phase ? cur.sym1 : cur.sym0;
  assign error      = phase ? 1'b0 : cur.err0;
  assign last       = phase || !cur.two;

  always_ff @(posedge clk) begin
    if (q_pop) cur <= q_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      phase     <= 1'b0;
    end else if (q_pop) begin
      cur_valid <= 1'b1;
      phase     <= 1'b0;
    end else if (advance) begin
      cur_valid <= 1'b0;
      phase     <= 1'b0;
    end else if (pop && cur_valid) begin
      phase     <= 1'b1;
    end
  end

endmodule

`default_nettype wire

/* rtl/polybius_square_cipher.sv */
// Top level of the 6x6 Polybius square cipher: config registers, front end, job queue,
// result stage. Depends on pbsq_pkg, pbsq_front, pbsq_queue and pbsq_back.
`default_nettype none

// Polybius square cipher over A-Z, space and 1-9, with the square rotated left by
// key_rotation (register 0, byte address 0; values 36..63 act modulo 36) and the
// direction set by decrypt_mode (register 1, byte address 4; 0 encrypts, 1 decrypts).
// Change the registers only while the block is idle. Input words go in with push/full,
// results come out with empty/pop, oldest first. Encrypting a byte gives two words
// (row header then column header, last on the second); an unknown byte gives one error
// word. Decrypting takes letter pairs: the first letter gives no word (or one error word
// when end_of_text is set), the second gives the decoded symbol or an error word.
// Error words carry out_symbol 0 and always have last set. Rate: the output side moves
// one word per cycle while pop stays high, so encryption sustains one input word per two
// output words and decryption one input word per cycle; the front end accepts while
// earlier words still wait, until the QUEUE_DEPTH-entry job queue fills. A pushed word's
// job goes through the job queue and the result stage register to the result ports.
module polybius_square_cipher #(
  parameter int QUEUE_DEPTH = pbsq_pkg::QueueDepth
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // config port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output      logic [31:0] prdata,
  output      logic        pready,
  // input words
  input  wire logic        push,
  output      logic        full,
  input  wire logic [7:0]  in_symbol,
  input  wire logic        end_of_text,
  // result words
  output      logic        empty,
  input  wire logic        pop,
  output      logic [7:0]  out_symbol,
  output      logic        error,
  output      logic        last
);
  import pbsq_pkg::*;

  logic [5:0] key_rotation;
  logic       decrypt_mode;
  logic       cfg_write;
  logic       accept;
  logic       job_valid;
  job_t       job;
  job_t       q_data;
  logic       q_empty;
  logic       q_full;
  logic       q_pop;

  // registers; only paddr[2] selects
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_rotation <= '0;
      decrypt_mode <= 1'b0;
    end else if (cfg_write) begin
      case (paddr[2])
        RegKey:  key_rotation <= pwdata[5:0];
        RegMode: decrypt_mode <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      RegKey:  prdata = {26'd0, key_rotation};
      RegMode: prdata = {31'd0, decrypt_mode};
      default: prdata = '0;
    endcase
  end

  // full is the queue's full; a word that makes no job still waits for room
  assign full   = q_full;
  assign accept = push && !q_full;

  pbsq_front u_front (
    .clk          (clk),
    .rst          (rst),
    .key_rotation (key_rotation),
    .decrypt_mode (decrypt_mode),
    .in_symbol    (in_symbol),
    .end_of_text  (end_of_text),
    .accept       (accept),
    .job_valid    (job_valid),
    .job          (job)
  );

  pbsq_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (job_valid),
    .wr_data (job),
    .rd_en   (q_pop),
    .rd_data (q_data),
    .full    (q_full),
    .empty   (q_empty)
  );

  pbsq_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_data     (q_data),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .out_symbol (out_symbol),
    .error      (error),
    .last       (last),
    .empty      (empty),
    .pop        (pop)
  );

endmodule

`default_nettype wire

/* rtl/pbsq_checker.sv */
// Port-level checks for polybius_square_cipher, and the bind that attaches them.
// Depends on the top level's ports only.
`default_nettype none

module pbsq_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       empty,
  input wire logic       pop,
  input wire logic [7:0] out_symbol,
  input wire logic       error,
  input wire logic       last
);

  // no word survives reset
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result word present after reset");

  // error words carry a zero symbol
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && error) |-> (out_symbol == 8'd0))
    else $error("error word with nonzero symbol");

  // an error word ends its input word's results
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && error) |-> last)
    else $error("error word without last");

  // a waiting word holds until popped
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_symbol) && $stable(error) && $stable(last)))
    else $error("waiting result word changed");

endmodule

bind polybius_square_cipher pbsq_checker u_pbsq_checker (
  .clk        (clk),
  .rst        (rst),
  .empty      (empty),
  .pop        (pop),
  .out_symbol (out_symbol),
  .error      (error),
  .last       (last)
);

`default_nettype wire

/* bench/tb_polybius_square_cipher.sv */
// Self-checking bench for polybius_square_cipher: random and directed text bytes
// against an in-bench cipher predictor, with word-by-word result checking.
// Depends on pbsq_pkg and the polybius_square_cipher RTL.
`timescale 1ns / 100ps

module tb_polybius_square_cipher;

  import pbsq_pkg::*;

  // register byte addresses, register i at 4*i
  localparam logic [2:0] KeyAddr  = 3'(4 * int'(RegKey));
  localparam logic [2:0] ModeAddr = 3'(4 * int'(RegMode));
  localparam logic [31:0] KeyMask  = 32'h0000_003F;
  localparam logic [31:0] ModeMask = 32'h0000_0001;

  // square contents in index order, plus the row and column header letters
  localparam logic [36*8-1:0] Glyphs = "ABCDEFGHIJKLMNOPQRSTUVWXYZ 123456789";
  localparam logic [47:0]     RowHdr = "NORMAL";
  localparam logic [47:0]     ColHdr = "XIFRAT";

  typedef enum logic {Encrypt = 1'b0, Decrypt = 1'b1} cipher_dir_t;

  typedef struct packed {
    logic [7:0] sym;
    logic       eot;
  } text_byte_t;

  typedef struct packed {
    logic [7:0] sym;
    logic       err;
    logic       last;
  } cipher_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  in_symbol = '0;
  logic        end_of_text = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [7:0]  out_symbol;
  logic        error;
  logic        last;

  polybius_square_cipher u_dut (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .push       (push),
    .full       (full),
    .in_symbol  (in_symbol),
    .end_of_text(end_of_text),
    .empty      (empty),
    .pop        (pop),
    .out_symbol (out_symbol),
    .error      (error),
    .last       (last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // hard stop well past the slowest legal run
  initial begin
    #5_000_000;
    $display("polybius_square_cipher: mismatch");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor: own copy of the registers and the half-pair state
  // ---------------------------------------------------------------------------
  logic [5:0]  key_reg = '0;
  cipher_dir_t mode_reg = Encrypt;
  logic        half_waiting = 1'b0;
  logic [2:0]  held_row = '0;
  logic        held_bad = 1'b0;

  text_byte_t   text_bytes_pending[$];
  cipher_word_t cipher_words_due[$];

  int items_queued = 0;
  int items_taken = 0;
  int words_checked = 0;
  int error_words = 0;
  int settings_seen = 0;
  int mismatches = 0;

  function automatic logic [7:0] glyph_at(input int i);
    return Glyphs[8*(35-i) +: 8];
  endfunction

  function automatic logic [7:0] header_at(input logic [47:0] tab, input int i);
    return tab[8*(5-i) +: 8];
  endfunction

  // 36 when the byte is not in the square
  function automatic int glyph_index(input logic [7:0] c);
    for (int i = 0; i < 36; i++)
      if (glyph_at(i) == c) return i;
    return 36;
  endfunction

  // 6 when the letter is not a header of that table
  function automatic int header_index(input logic [47:0] tab, input logic [7:0] c);
    for (int i = 0; i < 6; i++)
      if (header_at(tab, i) == c) return i;
    return 6;
  endfunction

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    return (c >= "a" && c <= "z") ? c - 8'h20 : c;
  endfunction

  task automatic expect_word(input logic [7:0] sym, input logic err, input logic lst);
    cipher_words_due.push_back('{sym: sym, err: err, last: lst});
  endtask

  task automatic predict_cipher_words(input logic [7:0] raw, input logic eot);
    logic [7:0] c;
    int key, a, p, r, col;
    logic bad;
    c = to_upper(raw);
    key = int'(key_reg) % 36;
    if (mode_reg == Encrypt) begin
      // encrypting always drops any held half pair
      half_waiting = 1'b0;
      held_row = '0;
      held_bad = 1'b0;
      a = glyph_index(c);
      if (a == 36) begin
        expect_word(8'h00, 1'b1, 1'b1);
      end else begin
        p = (a + 36 - key) % 36;
        expect_word(header_at(RowHdr, p / 6), 1'b0, 1'b0);
        expect_word(header_at(ColHdr, p % 6), 1'b0, 1'b1);
      end
    end else if (!half_waiting) begin
      r = header_index(RowHdr, c);
      if (eot) begin
        // lone row letter at end of text
        held_row = '0;
        held_bad = 1'b0;
        expect_word(8'h00, 1'b1, 1'b1);
      end else begin
        half_waiting = 1'b1;
        held_bad = (r == 6);
        held_row = held_bad ? 3'd0 : 3'(r);
      end
    end else begin
      col = header_index(ColHdr, c);
      bad = held_bad || (col == 6);
      if (bad) expect_word(8'h00, 1'b1, 1'b1);
      else expect_word(glyph_at((int'(held_row) * 6 + col + key) % 36), 1'b0, 1'b1);
      half_waiting = 1'b0;
      held_row = '0;
      held_bad = 1'b0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Handshake tracking, sampled at the rising edge
  // ---------------------------------------------------------------------------
  logic in_fire = 1'b0;
  logic out_fire = 1'b0;
  logic in_burst = 1'b0;
  logic out_burst = 1'b0;
  int   push_gap = 0;
  int   pop_wait = 0;
  text_byte_t next_byte;

  function automatic int draw_gap(input logic burst);
    return burst ? 0 : int'($urandom_range(0, 13));
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      in_fire = 1'b0;
      out_fire = 1'b0;
    end else begin
      in_fire = push && !full;
      out_fire = pop && !empty;
      if (in_fire) begin
        predict_cipher_words(in_symbol, end_of_text);
        items_taken++;
      end
      if (out_fire) begin
        words_checked++;
        if (error) error_words++;
        if (cipher_words_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected word sym %h err %b last %b",
                     $time, out_symbol, error, last);
        end else begin
          cipher_word_t want;
          want = cipher_words_due.pop_front();
          if (out_symbol !== want.sym || error !== want.err || last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: word %0d exp sym %h err %b last %b, got sym %h err %b last %b",
                       $time, words_checked, want.sym, want.err, want.last,
                       out_symbol, error, last);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input driver: holds push until the word is taken, then waits its gap
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst) begin
      if (!push || in_fire) begin
        if (push_gap > 0) begin
          push <= 1'b0;
          push_gap--;
        end else if (text_bytes_pending.size() != 0) begin
          next_byte = text_bytes_pending.pop_front();
          in_symbol <= next_byte.sym;
          end_of_text <= next_byte.eot;
          push <= 1'b1;
          push_gap = draw_gap(in_burst);
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Result side: a freshly drawn stall, which can be zero, after every accepted word
  always @(negedge clk) begin
    if (!rst) begin
      if (out_fire) pop_wait = draw_gap(out_burst);
      if (pop_wait > 0) begin
        pop <= 1'b0;
        pop_wait--;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_byte(input logic [7:0] sym, input logic eot);
    text_bytes_pending.push_back('{sym: sym, eot: eot});
    items_queued++;
  endtask

  // all bytes taken and all words back, then a short wait for a word in flight
  // that produces nothing (first letter of a pair)
  task automatic wait_idle();
    while (items_taken != items_queued || cipher_words_due.size() != 0)
      @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // APB write with junk in the unused upper bits, then a read back
  task automatic program_register(input logic [2:0] addr, input logic [31:0] value,
                                  input logic [31:0] mask);
    logic [31:0] bus;
    bus = $urandom();
    bus = (bus & ~mask) | (value & mask);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= bus;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == KeyAddr) key_reg = 6'(value & mask);
    else mode_reg = cipher_dir_t'(value[0]);
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== (value & mask)) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: register at %0d reads %h, exp %h", $time, addr, prdata, value & mask);
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apply_setting(input int key, input cipher_dir_t dir);
    program_register(KeyAddr, 32'(key), KeyMask);
    program_register(ModeAddr, 32'(dir), ModeMask);
    settings_seen++;
  endtask

  function automatic logic [7:0] random_case(input logic [7:0] c);
    return (c >= "A" && c <= "Z" && $urandom_range(0, 1)) ? c + 8'h20 : c;
  endfunction

  // Encrypt: mostly square symbols, some arbitrary bytes.
  // Decrypt: mostly well-formed header pairs, the rest lone row letters at end
  // of text and arbitrary bytes that break the pairing.
  task automatic random_text(input int count);
    int n, r;
    n = 0;
    while (n < count) begin
      if ($urandom_range(0, 24) == 0) begin
        in_burst = ($urandom_range(0, 2) == 0);
        out_burst = ($urandom_range(0, 2) == 0);
      end
      r = $urandom_range(0, 99);
      if (mode_reg == Encrypt) begin
        if (r < 85) queue_byte(random_case(glyph_at($urandom_range(0, 35))),
                               $urandom_range(0, 7) == 0);
        else queue_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
        n++;
      end else if (r < 80) begin
        queue_byte(random_case(header_at(RowHdr, $urandom_range(0, 5))), 1'b0);
        queue_byte(random_case(header_at(ColHdr, $urandom_range(0, 5))),
                   $urandom_range(0, 3) == 0);
        n += 2;
      end else if (r < 88) begin
        queue_byte(random_case(header_at(RowHdr, $urandom_range(0, 5))), 1'b1);
        n++;
      end else begin
        queue_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
        n++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // encrypt at reset values: square edges, space, lower case, unknown bytes
    queue_byte("A", 1'b0);
    queue_byte("z", 1'b0);
    queue_byte("9", 1'b0);
    queue_byte(" ", 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h7B, 1'b0);
    queue_byte("m", 1'b1);
    wait_idle();
    settings_seen++;

    // decrypt with the largest in-range key
    apply_setting(35, Decrypt);
    queue_byte("N", 1'b0);  // first cell
    queue_byte("X", 1'b0);
    queue_byte("l", 1'b0);  // last cell, lower case headers
    queue_byte("t", 1'b0);
    queue_byte("Q", 1'b0);  // unknown row letter
    queue_byte("X", 1'b0);
    queue_byte("N", 1'b0);  // unknown column letter
    queue_byte("Q", 1'b0);
    queue_byte(" ", 1'b0);  // space is no header
    queue_byte("X", 1'b0);
    queue_byte("R", 1'b1);  // half pair at end of text
    queue_byte("O", 1'b0);  // end flag on the second letter
    queue_byte("F", 1'b1);
    queue_byte("O", 1'b0);  // left held into the next setting
    wait_idle();

    // key above range, and encryption drops the held half pair
    apply_setting(63, Encrypt);
    queue_byte("B", 1'b0);
    queue_byte("9", 1'b0);
    wait_idle();

    for (int ph = 0; ph < 8; ph++) begin
      int key;
      cipher_dir_t dir;
      case (ph)
        0:       key = 0;
        1:       key = 35;
        2:       key = 63;
        3:       key = 36;
        default: key = $urandom_range(0, 63);
      endcase
      dir = (ph < 4) ? cipher_dir_t'(ph % 2) : cipher_dir_t'($urandom_range(0, 1));
      apply_setting(key, dir);
      random_text(100);
      wait_idle();
    end

    repeat (10) @(negedge clk);
    if (cipher_words_due.size() != 0)
      $display("%0d expected words never came out", cipher_words_due.size());
    $display("ran %0d text bytes under %0d key/mode settings", items_taken, settings_seen);
    $display("checked %0d result words, %0d of them error words", words_checked, error_words);
    if (mismatches == 0 && cipher_words_due.size() == 0) begin
      $display("polybius_square_cipher: match");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("polybius_square_cipher: mismatch");
    end
    $finish;
  end

endmodule
